// File: rtl/wsg_pkg.sv
`timescale 1ns / 1ps

package wsg_pkg;

  // field widths
  localparam int REQ_W      = 2;
  localparam int TBL_AW     = 8;
  localparam int NIB_W      = 4;
  localparam int MIX_W      = 10;

  // sound register file
  localparam int REG_N      = 32;
  localparam int REG_AW     = 5;

  // sample counter and phase
  localparam int CNT_W       = 20;
  localparam int PHASE_W     = 5;
  localparam int PHASE_SHIFT = CNT_W - PHASE_W;
  localparam int STEP_W      = $clog2(CNT_W);
  localparam int SHAPE_W     = TBL_AW - PHASE_W;

  // voice count default
  localparam int VOICES     = 3;

  // product of biased sample and volume, 5-bit signed by 5-bit signed
  localparam int PROD_W     = 9;

  // request codes
  localparam logic [REQ_W-1:0] REQ_REG_WR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TBL_WR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

  // register map
  localparam logic [REG_AW-1:0] REG_FREQ0_LO   = 5'h10;
  localparam int                REG_FREQ_BASE  = 'h11;
  localparam int                REG_VOL_BASE   = 'h15;
  localparam int                REG_SHAPE_BASE = 'h05;
  localparam int                VOICE_STRIDE   = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FETCH,
    ST_ACC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
  } lane_ctl_t;

  // frequency nibble k (1..4 maps to k = 0..3) of voice v
  function automatic logic [REG_AW-1:0] freq_addr(input int v, input int k);
    freq_addr = REG_AW'(REG_FREQ_BASE + VOICE_STRIDE * v + k);
  endfunction

  function automatic logic [REG_AW-1:0] vol_addr(input int v);
    vol_addr = REG_AW'(REG_VOL_BASE + VOICE_STRIDE * v);
  endfunction

  function automatic logic [REG_AW-1:0] shape_addr(input int v);
    shape_addr = REG_AW'(REG_SHAPE_BASE + VOICE_STRIDE * v);
  endfunction

endpackage

// File: rtl/wsg_req_if.sv
`timescale 1ns / 1ps

interface wsg_req_if;
  logic                          valid;
  logic                          ready;
  logic [wsg_pkg::REQ_W-1:0]     req_type;
  logic [wsg_pkg::TBL_AW-1:0]    target_addr;
  logic [wsg_pkg::NIB_W-1:0]     write_nibble;

  modport source (output valid, req_type, target_addr, write_nibble, input ready);
  modport sink   (input valid, req_type, target_addr, write_nibble, output ready);
endinterface

// File: rtl/wsg_mix_if.sv
`timescale 1ns / 1ps

interface wsg_mix_if;
  logic                             valid;
  logic                             ready;
  logic signed [wsg_pkg::MIX_W-1:0] mix_sample;

  modport source (output valid, mix_sample, input ready);
  modport sink   (input valid, mix_sample, output ready);
endinterface

// File: rtl/wsg_mul_lane.sv
`timescale 1ns / 1ps

// shift-add multiplier, one multiplier bit per cycle while shift is set, low product bits only
module wsg_mul_lane (
  input  logic                               clk,
  input  wsg_pkg::lane_ctl_t                 ctl,
  input  logic [wsg_pkg::CNT_W-1:0]          mcand_in,
  input  logic [wsg_pkg::CNT_W-1:0]          mplier_in,
  output logic [wsg_pkg::PHASE_W-1:0]        phase
);

  logic [wsg_pkg::CNT_W-1:0] mcand;
  logic [wsg_pkg::CNT_W-1:0] mplier;
  logic [wsg_pkg::CNT_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mcand  <= mcand_in;
      mplier <= mplier_in;
      acc    <= '0;
    end else if (ctl.shift) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= {mcand[wsg_pkg::CNT_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[wsg_pkg::CNT_W-1:1]};
    end
  end

  assign phase = acc[wsg_pkg::CNT_W-1:wsg_pkg::PHASE_SHIFT];

endmodule

// File: rtl/wavetable_sound_generator_3voice_top.sv
`timescale 1ns / 1ps

// Three-voice wavetable sound generator. Request transactions on req either write a
// four-bit sound register (low 5 address bits), write a four-bit entry of the 256-entry
// waveform table, or tick the 20-bit sample counter; only a tick returns a transaction
// on mix, carrying the signed sum over voices of (sample - 8) * volume, or 0 while
// sound_enable is clear. Voices with zero frequency or zero volume are silent. A tick
// keeps req.ready low until its mix is in the output register: the bit-serial
// counter-times-frequency multiply (one multiplier bit per cycle, all voices side by
// side), then a fetch and an accumulate step per voice on the single read port of the
// waveform table, and a step that moves the mix into the output register; that last step
// stretches for as long as the previous mix still waits there unclaimed. The result waits
// there while new transactions are taken.
// req.ready is low during reset. Table entries that were never written read back
// undefined.
module wavetable_sound_generator_3voice_top #(
  parameter int VOICES = wsg_pkg::VOICES
) (
  input  logic            clk,
  input  logic            rst,
  wsg_req_if.sink         req,
  wsg_mix_if.source       mix,
  input  logic            cfg_we,
  input  logic            cfg_wdata
);

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

  // control
  wsg_pkg::state_t               state;
  wsg_pkg::state_t               state_next;
  logic [wsg_pkg::STEP_W-1:0]    step;
  logic [VW-1:0]                 voice;
  wsg_pkg::lane_ctl_t            lane_ctl;

  logic                          in_accept;
  logic                          tick_accept;
  logic                          reg_we;
  logic                          tbl_we;
  logic                          load_out;

  // state
  logic [wsg_pkg::NIB_W-1:0]     sound_regs [wsg_pkg::REG_N];
  logic [wsg_pkg::NIB_W-1:0]     wave_mem   [2**wsg_pkg::TBL_AW];
  logic [wsg_pkg::CNT_W-1:0]     sample_count;
  logic [wsg_pkg::CNT_W-1:0]     sample_count_next;
  logic                          sound_enable;

  // datapath
  logic [wsg_pkg::CNT_W-1:0]     freq   [VOICES];
  logic [wsg_pkg::NIB_W-1:0]     vol    [VOICES];
  logic [wsg_pkg::SHAPE_W-1:0]   shape  [VOICES];
  logic [wsg_pkg::PHASE_W-1:0]   phase  [VOICES];
  logic [VOICES-1:0]             active;

  logic [wsg_pkg::TBL_AW-1:0]    rd_addr;
  logic [wsg_pkg::NIB_W-1:0]     wave_rd;
  logic signed [wsg_pkg::NIB_W:0]  samp_s;
  logic signed [wsg_pkg::NIB_W:0]  vol_s;
  logic signed [wsg_pkg::PROD_W-1:0] prod;
  logic signed [wsg_pkg::MIX_W-1:0]  mix_acc;

  // output register
  logic                              out_valid;
  logic signed [wsg_pkg::MIX_W-1:0]  out_data;

  assign in_accept   = req.valid && req.ready;
  assign tick_accept = in_accept && (req.req_type == wsg_pkg::REQ_TICK);
  assign reg_we      = in_accept && (req.req_type == wsg_pkg::REQ_REG_WR);
  assign tbl_we      = in_accept && (req.req_type == wsg_pkg::REQ_TBL_WR);

  assign sample_count_next = sample_count + wsg_pkg::CNT_W'(1);

  // per-voice register decode and multiply lanes
  for (genvar v = 0; v < VOICES; v++) begin : g_voice
    logic [wsg_pkg::NIB_W-1:0] freq_lo;

    // only voice 0 has a programmable low frequency nibble
    assign freq_lo = (v == 0) ? sound_regs[wsg_pkg::REG_FREQ0_LO] : '0;
    assign freq[v] = {sound_regs[wsg_pkg::freq_addr(v, 3)],
                      sound_regs[wsg_pkg::freq_addr(v, 2)],
                      sound_regs[wsg_pkg::freq_addr(v, 1)],
                      sound_regs[wsg_pkg::freq_addr(v, 0)],
                      freq_lo};
    assign vol[v]    = sound_regs[wsg_pkg::vol_addr(v)];
    assign shape[v]  = sound_regs[wsg_pkg::shape_addr(v)][wsg_pkg::SHAPE_W-1:0];
    // silent voices skip the table read result entirely
    assign active[v] = (freq[v] != '0) && (vol[v] != '0);

    wsg_mul_lane u_lane (
      .clk       (clk),
      .ctl       (lane_ctl),
      .mcand_in  (sample_count_next),
      .mplier_in (freq[v]),
      .phase     (phase[v])
    );
  end

  // sound register file, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < wsg_pkg::REG_N; i++) begin
        sound_regs[i] <= '0;
      end
    end else if (reg_we) begin
      sound_regs[req.target_addr[wsg_pkg::REG_AW-1:0]] <= req.write_nibble;
    end
  end

  // waveform table: one write port, one registered read port
  assign rd_addr = {shape[voice], phase[voice]};

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      wave_mem[req.target_addr] <= req.write_nibble;
    end
    wave_rd <= wave_mem[rd_addr];
  end

  // sample counter advances on every tick, enabled or not
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
    end else if (tick_accept) begin
      sample_count <= sample_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sound_enable <= 1'b0;
    end else if (cfg_we) begin
      sound_enable <= cfg_wdata;
    end
  end

  // sample - 8 is the nibble with its top bit flipped, read as signed
  assign samp_s = (wsg_pkg::NIB_W+1)'(signed'({~wave_rd[wsg_pkg::NIB_W-1],
                                               wave_rd[wsg_pkg::NIB_W-2:0]}));
  assign vol_s  = signed'({1'b0, vol[voice]});
  assign prod   = wsg_pkg::PROD_W'(samp_s) * wsg_pkg::PROD_W'(vol_s);

  always_ff @(posedge clk) begin
    if (tick_accept) begin
      mix_acc <= '0;
    end else if (state == wsg_pkg::ST_ACC && active[voice]) begin
      mix_acc <= mix_acc + wsg_pkg::MIX_W'(prod);
    end
  end

  // step and voice counters
  always_ff @(posedge clk) begin
    if (rst) begin
      step  <= '0;
      voice <= '0;
    end else begin
      if (tick_accept) begin
        step <= '0;
      end else if (state == wsg_pkg::ST_MUL) begin
        step <= step + wsg_pkg::STEP_W'(1);
      end
      if (tick_accept) begin
        voice <= '0;
      end else if (state == wsg_pkg::ST_ACC && voice != VW'(VOICES - 1)) begin
        voice <= voice + VW'(1);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      wsg_pkg::ST_IDLE: begin
        if (tick_accept) begin
          state_next = wsg_pkg::ST_MUL;
        end
      end
      wsg_pkg::ST_MUL: begin
        if (step == wsg_pkg::STEP_W'(wsg_pkg::CNT_W - 1)) begin
          state_next = wsg_pkg::ST_FETCH;
        end
      end
      wsg_pkg::ST_FETCH: begin
        state_next = wsg_pkg::ST_ACC;
      end
      wsg_pkg::ST_ACC: begin
        if (voice == VW'(VOICES - 1)) begin
          state_next = wsg_pkg::ST_DONE;
        end else begin
          state_next = wsg_pkg::ST_FETCH;
        end
      end
      wsg_pkg::ST_DONE: begin
        if (!out_valid || mix.ready) begin
          state_next = wsg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wsg_pkg::ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    req.ready      = 1'b0;
    lane_ctl.load  = 1'b0;
    lane_ctl.shift = 1'b0;
    load_out       = 1'b0;
    unique case (state)
      wsg_pkg::ST_IDLE: begin
        // nothing is taken while reset is held
        req.ready     = !rst;
        lane_ctl.load = tick_accept;
      end
      wsg_pkg::ST_MUL: begin
        lane_ctl.shift = 1'b1;
      end
      wsg_pkg::ST_FETCH, wsg_pkg::ST_ACC: begin
      end
      wsg_pkg::ST_DONE: begin
        load_out = !out_valid || mix.ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wsg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output register holds the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (mix.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= sound_enable ? mix_acc : '0;
    end
  end

  assign mix.valid      = out_valid;
  assign mix.mix_sample = out_data;

endmodule

// File: rtl/wsg_checker.sv
`timescale 1ns / 1ps

module wsg_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic [wsg_pkg::REQ_W-1:0]          in_req_type,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [wsg_pkg::MIX_W-1:0]   out_mix
);

  // a taken tick keeps the request side busy in the next cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_req_type == wsg_pkg::REQ_TICK) |=> !in_ready)
    else $error("request taken right after a tick");

  // mix always stays within three voices of full-scale product
  a_mix_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_mix >= -10'sd360 && out_mix <= 10'sd315))
    else $error("mix sample out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("mix transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(out_mix))
    else $error("mix payload changed while stalled");

endmodule

bind wavetable_sound_generator_3voice_top wsg_checker u_wsg_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .in_req_type (req.req_type),
  .out_valid   (mix.valid),
  .out_ready   (mix.ready),
  .out_mix     (mix.mix_sample)
);

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  // request code with no meaning: the block takes it and drops it
  localparam logic [wsg_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  // busy time of one tick, plus margin before touching the enable
  localparam int TICK_CYCLES      = 21 + 2 * wsg_pkg::VOICES;
  localparam int SETTLE_CYCLES    = TICK_CYCLES + 8;
  // long receiver hold-off so the output register and the tick path back up
  localparam int SINK_HOLD_CYCLES = 300;
  // cycles without any transaction before the run is declared hung
  localparam int QUIET_LIMIT      = 4000;
  // upper address bits that the register file ignores
  localparam logic [wsg_pkg::TBL_AW-1:0] ALIAS_BITS = 8'hE0;

  typedef enum logic [1:0] {
    PACE_SLOW_SINK,
    PACE_SLOW_SOURCE,
    PACE_FULL
  } pace_t;

  typedef enum logic [2:0] {
    STEP_REQ,
    STEP_DRAIN,
    STEP_CFG,
    STEP_PACE,
    STEP_SINK_HOLD
  } step_kind_t;

  typedef struct {
    step_kind_t                    kind;
    logic [wsg_pkg::REQ_W-1:0]     req_type;
    logic [wsg_pkg::TBL_AW-1:0]    addr;
    logic [wsg_pkg::NIB_W-1:0]     nibble;
    int                            arg;
  } plan_step_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  wsg_req_if req_bus ();
  wsg_mix_if mix_bus ();

  wavetable_sound_generator_3voice_top uut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_bus),
    .mix       (mix_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // predictor state: register file, waveform table, counter, enable
  // ---------------------------------------------------------------------
  logic [wsg_pkg::NIB_W-1:0]        snd_regs [wsg_pkg::REG_N];
  logic [wsg_pkg::NIB_W-1:0]        wave_mem [1 << wsg_pkg::TBL_AW];
  logic [wsg_pkg::CNT_W-1:0]        tick_count = '0;
  logic                             mix_enable = 1'b0;
  logic signed [wsg_pkg::MIX_W-1:0] mix_expect [$];

  // bookkeeping
  int n_ticks     = 0;
  int n_reg_wr    = 0;
  int n_tbl_wr    = 0;
  int n_ignored   = 0;
  int n_checked   = 0;
  int n_fail      = 0;
  int quiet_cycles = 0;

  // 20-bit frequency of a voice; only voice 0 owns a low nibble
  function automatic logic [wsg_pkg::CNT_W-1:0] predicted_freq(input int v);
    int                        base;
    logic [wsg_pkg::CNT_W-1:0] f;
    base = wsg_pkg::REG_FREQ_BASE + wsg_pkg::VOICE_STRIDE * v;
    f = (v == 0) ? wsg_pkg::CNT_W'(snd_regs[wsg_pkg::REG_FREQ0_LO]) : '0;
    for (int k = 0; k < 4; k++)
      f |= wsg_pkg::CNT_W'(snd_regs[(base + k) % wsg_pkg::REG_N]) << (wsg_pkg::NIB_W * (k + 1));
    return f;
  endfunction

  // mix for the current counter value
  function automatic logic signed [wsg_pkg::MIX_W-1:0] mixed_sample();
    int                          total;
    logic [wsg_pkg::CNT_W-1:0]   f;
    logic [wsg_pkg::NIB_W-1:0]   vol;
    logic [wsg_pkg::NIB_W-1:0]   shape;
    logic [2*wsg_pkg::CNT_W-1:0] prod;
    logic [wsg_pkg::TBL_AW-1:0]  idx;
    total = 0;
    if (mix_enable) begin
      for (int v = 0; v < wsg_pkg::VOICES; v++) begin
        f     = predicted_freq(v);
        vol   = snd_regs[(wsg_pkg::REG_VOL_BASE + wsg_pkg::VOICE_STRIDE * v) % wsg_pkg::REG_N];
        shape = snd_regs[(wsg_pkg::REG_SHAPE_BASE + wsg_pkg::VOICE_STRIDE * v) % wsg_pkg::REG_N];
        // silent voice: zero frequency or zero volume adds nothing
        if (f != '0 && vol != '0) begin
          prod  = tick_count * f;
          idx   = {shape[wsg_pkg::SHAPE_W-1:0], prod[wsg_pkg::PHASE_SHIFT +: wsg_pkg::PHASE_W]};
          total += (int'(wave_mem[idx]) - 8) * int'(vol);
        end
      end
    end
    return wsg_pkg::MIX_W'(total);
  endfunction

  // update the predictor with one accepted request transaction
  task automatic take_request(input logic [wsg_pkg::REQ_W-1:0] kind,
                              input logic [wsg_pkg::TBL_AW-1:0] addr,
                              input logic [wsg_pkg::NIB_W-1:0] nib);
    case (kind)
      wsg_pkg::REQ_REG_WR: begin
        snd_regs[addr[wsg_pkg::REG_AW-1:0]] = nib;
        n_reg_wr++;
      end
      wsg_pkg::REQ_TBL_WR: begin
        wave_mem[addr] = nib;
        n_tbl_wr++;
      end
      wsg_pkg::REQ_TICK: begin
        tick_count = tick_count + 1'b1;
        mix_expect = {mix_expect, mixed_sample()};
        n_ticks++;
      end
      default: begin
        n_ignored++;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // stimulus plan: requests mixed with control steps for the driver
  // ---------------------------------------------------------------------
  plan_step_t plan [$];

  task automatic plan_req(input logic [wsg_pkg::REQ_W-1:0] kind,
                          input logic [wsg_pkg::TBL_AW-1:0] addr,
                          input logic [wsg_pkg::NIB_W-1:0] nib);
    plan_step_t s;
    s.kind     = STEP_REQ;
    s.req_type = kind;
    s.addr     = addr;
    s.nibble   = nib;
    s.arg      = 0;
    plan = {plan, s};
  endtask

  task automatic plan_ctl(input step_kind_t kind, input int arg);
    plan_step_t s;
    s.kind     = kind;
    s.req_type = wsg_pkg::REQ_REG_WR;
    s.addr     = '0;
    s.nibble   = '0;
    s.arg      = arg;
    plan = {plan, s};
  endtask

  // enable changes only once every tick has come back and the block has settled
  task automatic plan_enable(input int value);
    plan_ctl(STEP_DRAIN, 0);
    plan_ctl(STEP_CFG, value);
  endtask

  // random mix of ticks and writes; ignored codes come on top of the count
  task automatic plan_random(input int n);
    int made;
    int roll;
    made = 0;
    while (made < n) begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        plan_req(REQ_UNUSED, 8'($urandom), 4'($urandom));
      end else begin
        if (roll < 42)
          plan_req(wsg_pkg::REQ_TICK, 8'($urandom), 4'($urandom));
        else if (roll < 78)
          plan_req(wsg_pkg::REQ_REG_WR, 8'($urandom), 4'($urandom));
        else
          plan_req(wsg_pkg::REQ_TBL_WR, 8'($urandom), 4'($urandom));
        made++;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // driver: offers planned transactions at the falling edge
  // ---------------------------------------------------------------------
  pace_t pace          = PACE_SLOW_SINK;
  logic  req_took      = 1'b0;
  int    settle_left   = 0;
  int    hold_requests = 0;
  int    hold_served   = 0;
  int    hold_left     = 0;

  always @(negedge clk) begin
    logic       offer;
    logic       cfg_now;
    int         idle_pct;
    plan_step_t head;
    offer    = 1'b0;
    cfg_now  = 1'b0;
    idle_pct = (pace == PACE_SLOW_SINK) ? 18 : (pace == PACE_SLOW_SOURCE) ? 81 : 0;
    if (rst) begin
      // nothing offered during reset
    end else if (req_bus.valid && !req_took) begin
      // transaction not taken yet: keep it on the bus
      offer = 1'b1;
    end else if (settle_left > 0) begin
      settle_left--;
    end else if (plan.size() != 0) begin
      head = plan[0];
      case (head.kind)
        STEP_REQ: begin
          if ($urandom_range(99) >= idle_pct) begin
            req_bus.req_type     <= head.req_type;
            req_bus.target_addr  <= head.addr;
            req_bus.write_nibble <= head.nibble;
            offer = 1'b1;
            void'(plan.pop_front());
          end
        end
        STEP_DRAIN: begin
          // sender pause: wait for every outstanding mix sample
          if (mix_expect.size() == 0) begin
            settle_left = SETTLE_CYCLES;
            void'(plan.pop_front());
          end
        end
        STEP_CFG: begin
          cfg_now = 1'b1;
          cfg_wdata <= head.arg[0];
          void'(plan.pop_front());
        end
        STEP_PACE: begin
          pace <= pace_t'(head.arg);
          void'(plan.pop_front());
        end
        STEP_SINK_HOLD: begin
          hold_requests <= hold_requests + 1;
          void'(plan.pop_front());
        end
        default: begin
          void'(plan.pop_front());
        end
      endcase
    end
    req_bus.valid <= offer;
    cfg_we        <= cfg_now;
  end

  // ---------------------------------------------------------------------
  // receiver: random back-pressure plus an occasional long hold-off
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    int idle_pct;
    idle_pct = (pace == PACE_SLOW_SINK) ? 81 : (pace == PACE_SLOW_SOURCE) ? 18 : 0;
    if (hold_served != hold_requests) begin
      hold_left = SINK_HOLD_CYCLES;
      hold_served++;
    end
    if (rst) begin
      mix_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      mix_bus.ready <= 1'b0;
    end else begin
      mix_bus.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // monitor: sample both channels and the enable write at the rising edge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    logic signed [wsg_pkg::MIX_W-1:0] want;
    logic                             busy;
    req_took = 1'b0;
    if (!rst) begin
      busy = cfg_we;
      if (cfg_we)
        mix_enable = cfg_wdata;
      // check the result before predicting, so a stray result is never masked
      if (mix_bus.valid && mix_bus.ready) begin
        busy = 1'b1;
        n_checked++;
        if (mix_expect.size() == 0) begin
          $error("mix_sample: no result expected, got %0d", mix_bus.mix_sample);
          n_fail++;
        end else begin
          want = mix_expect.pop_front();
          if (mix_bus.mix_sample !== want) begin
            $error("mix_sample: expected %0d, got %0d", want, mix_bus.mix_sample);
            n_fail++;
          end
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        busy     = 1'b1;
        req_took = 1'b1;
        take_request(req_bus.req_type, req_bus.target_addr, req_bus.write_nibble);
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
    end
  end

  // watchdog: ends a hung run
  initial begin
    while (quiet_cycles < QUIET_LIMIT)
      @(posedge clk);
    $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    req_bus.valid        = 1'b0;
    req_bus.req_type     = wsg_pkg::REQ_REG_WR;
    req_bus.target_addr  = '0;
    req_bus.write_nibble = '0;
    mix_bus.ready        = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = 1'b0;
    rst                  = 1'b1;
    foreach (snd_regs[i])
      snd_regs[i] = '0;

    // load the whole table before any tick so no unwritten entry is read;
    // shape 0 is all minimum, shape 1 all maximum, the rest random
    for (int i = 0; i < (1 << wsg_pkg::TBL_AW); i++) begin
      if (i < 32)
        plan_req(wsg_pkg::REQ_TBL_WR, 8'(i), 4'h0);
      else if (i < 64)
        plan_req(wsg_pkg::REQ_TBL_WR, 8'(i), 4'hF);
      else
        plan_req(wsg_pkg::REQ_TBL_WR, 8'(i), 4'($urandom));
    end

    // directed: all voices loud on shape 0, some through aliased addresses
    plan_req(wsg_pkg::REQ_REG_WR, 8'(wsg_pkg::REG_FREQ0_LO), 4'h1);
    plan_req(wsg_pkg::REQ_REG_WR, ALIAS_BITS | 8'(wsg_pkg::REG_VOL_BASE), 4'hF);
    plan_req(wsg_pkg::REQ_REG_WR, 8'(wsg_pkg::REG_SHAPE_BASE), 4'h8);
    plan_req(wsg_pkg::REQ_REG_WR, 8'(wsg_pkg::REG_FREQ_BASE + wsg_pkg::VOICE_STRIDE), 4'h1);
    plan_req(wsg_pkg::REQ_REG_WR, 8'(wsg_pkg::REG_VOL_BASE + wsg_pkg::VOICE_STRIDE), 4'hF);
    plan_req(wsg_pkg::REQ_REG_WR, 8'(wsg_pkg::REG_SHAPE_BASE + wsg_pkg::VOICE_STRIDE), 4'h0);
    plan_req(wsg_pkg::REQ_REG_WR,
             ALIAS_BITS | 8'(wsg_pkg::REG_FREQ_BASE + 2 * wsg_pkg::VOICE_STRIDE + 3), 4'hF);
    plan_req(wsg_pkg::REQ_REG_WR,
             ALIAS_BITS | 8'(wsg_pkg::REG_VOL_BASE + 2 * wsg_pkg::VOICE_STRIDE), 4'hF);
    plan_req(wsg_pkg::REQ_REG_WR,
             8'(wsg_pkg::REG_SHAPE_BASE + 2 * wsg_pkg::VOICE_STRIDE), 4'h0);
    // sound still disabled: tick gives silence
    plan_req(wsg_pkg::REQ_TICK, 8'hFF, 4'hF);
    // unknown request code is dropped
    plan_req(REQ_UNUSED, 8'hFF, 4'hF);
    plan_enable(1);
    // most negative mix
    plan_req(wsg_pkg::REQ_TICK, 8'h00, 4'h0);
    // most positive mix, shape bit 3 ignored on voice 1
    plan_req(wsg_pkg::REQ_REG_WR, 8'(wsg_pkg::REG_SHAPE_BASE), 4'h1);
    plan_req(wsg_pkg::REQ_REG_WR, 8'(wsg_pkg::REG_SHAPE_BASE + wsg_pkg::VOICE_STRIDE), 4'h9);
    plan_req(wsg_pkg::REQ_REG_WR,
             8'(wsg_pkg::REG_SHAPE_BASE + 2 * wsg_pkg::VOICE_STRIDE), 4'h1);
    plan_req(wsg_pkg::REQ_TICK, 8'h00, 4'h0);
    // voice 1 silenced by volume, then voice 0 by frequency
    plan_req(wsg_pkg::REQ_REG_WR, 8'(wsg_pkg::REG_VOL_BASE + wsg_pkg::VOICE_STRIDE), 4'h0);
    plan_req(wsg_pkg::REQ_TICK, 8'h00, 4'h0);
    plan_req(wsg_pkg::REQ_REG_WR, 8'(wsg_pkg::REG_FREQ0_LO), 4'h0);
    plan_req(wsg_pkg::REQ_TICK, 8'h00, 4'h0);

    // random, slow receiver, with a long hold-off in the middle
    plan_random(280);
    plan_ctl(STEP_SINK_HOLD, 0);
    plan_random(120);
    plan_enable(0);
    plan_random(100);
    // random, slow sender
    plan_enable(1);
    plan_ctl(STEP_PACE, PACE_SLOW_SOURCE);
    plan_random(360);
    // random, no idling on either side, another long hold-off
    plan_ctl(STEP_PACE, PACE_FULL);
    plan_random(200);
    plan_ctl(STEP_SINK_HOLD, 0);
    plan_random(200);

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // run until the plan is used up and every mix sample is back
    while (plan.size() != 0 || req_bus.valid || mix_expect.size() != 0 || settle_left != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d request transactions: %0d ticks, %0d register writes,",
             n_ticks + n_reg_wr + n_tbl_wr + n_ignored, n_ticks, n_reg_wr);
    $display("  %0d table writes, %0d ignored codes", n_tbl_wr, n_ignored);
    $display("checked %0d mix samples over three pacing modes with sound on and off",
             n_checked);
    if (n_fail == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
